// ===== hdl/bmhq_pkg.sv =====
// Shared types and constants for the binary min-heap queue.
// Used by bmhq_cell, binary_min_heap_queue_unit and its checker.
package bmhq_pkg;

   localparam int DATA_W     = 32;
   localparam int CAP_W      = 5;
   localparam int OCC_W      = 5;
   localparam int STAT_W     = 2;
   localparam int DEF_DEPTH  = 16;
   localparam int CAP_RESET  = 16;
   localparam int RSP_DATA_W = 40;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_REMOVED  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

   localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

   // Operation broadcast to every cell of the chain.
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [DATA_W-1:0] value;
   } cmd_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      logic              take;
      logic [DATA_W-1:0] data;
   } link_type;

endpackage

// ===== hdl/bmhq_cell.sv =====
// One slot of the sorted cell chain: holds one entry, takes its left neighbor's
// entry or the new value on insert, and its right neighbor's entry on remove.
// Depends on bmhq_pkg.
module bmhq_cell (
   input  logic               clock,
   input  bmhq_pkg::cmd_type  cmd,
   input  logic               occupied,
   input  bmhq_pkg::link_type left_link,
   input  logic [bmhq_pkg::DATA_W-1:0] right_data,
   output bmhq_pkg::link_type self_link
);

   logic [bmhq_pkg::DATA_W-1:0] data_ff;
   logic [bmhq_pkg::DATA_W-1:0] data_in;
   logic                        take;

   // The new value belongs at or before this slot.
   assign take = !occupied || ($signed(cmd.value) < $signed(data_ff));

   always_comb begin
      data_in = data_ff;
      if (cmd.push && take) begin
         data_in = left_link.take ? left_link.data : cmd.value;
      end else if (cmd.pop) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign self_link.take = take;
   assign self_link.data = data_ff;

endmodule

// ===== hdl/binary_min_heap_queue_unit.sv =====
// Top level of the min-priority queue: a chain of bmhq_cell slots kept in
// ascending order, an entry counter, the capacity register and the result register.
// Depends on bmhq_pkg and bmhq_cell.
//
//   channel | ports              | tdata (low bit up)                  | tuser
//   --------+--------------------+-------------------------------------+--------
//   request | req_tvalid/tready  | value[31:0]                         | kind
//   result  | rsp_tvalid/tready  | result_value[31:0], occupancy[36:32]| status
//   csr     | csr_wr_en          | capacity[4:0]                       | -
//
// One item per cycle while no result is stalled: every cell compares the new value
// with its own entry in parallel and shifts by one slot; an item is done when taken.
// The result register holds a result until it is taken; a new item is taken in
// the same cycle the old result leaves. Reset clears the count, the capacity
// (to 16) and the result valid; cell contents are not cleared.
module binary_min_heap_queue_unit #(
   parameter int DEPTH = bmhq_pkg::DEF_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bmhq_pkg::DATA_W-1:0]       req_tdata,  // value
   input  logic                              req_tuser,  // kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bmhq_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // result_value, occupancy, zero pad
   output logic [bmhq_pkg::STAT_W-1:0]       rsp_tuser,  // status
   input  logic                              csr_wr_en,
   input  logic [bmhq_pkg::CAP_W-1:0]        csr_wr_data // capacity
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > bmhq_pkg::CAP_W) ? CNT_W : bmhq_pkg::CAP_W;

   logic [CNT_W-1:0]             count_ff, count_in;
   logic [bmhq_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bmhq_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [bmhq_pkg::OCC_W-1:0]   rsp_occ_ff, rsp_occ_in;
   logic [bmhq_pkg::STAT_W-1:0]  rsp_stat_ff, rsp_stat_in;

   logic                         xfer;
   logic                         full;
   logic                         empty;
   bmhq_pkg::cmd_type            cmd;
   bmhq_pkg::link_type           links [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign xfer       = req_tvalid && req_tready;

   assign full  = (count_ff == CNT_W'(DEPTH)) || (CMP_W'(count_ff) >= CMP_W'(cap_ff));
   assign empty = (count_ff == '0);

   always_comb begin
      cmd.push  = xfer && (req_tuser == bmhq_pkg::KIND_INSERT) && !full;
      cmd.pop   = xfer && (req_tuser == bmhq_pkg::KIND_REMOVE) && !empty;
      cmd.value = req_tdata;
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         bmhq_pkg::link_type left_link;
         logic [bmhq_pkg::DATA_W-1:0] right_data;
         if (g == 0) begin : g_head
            assign left_link = '0;
         end else begin : g_body
            assign left_link = links[g-1];
         end
         if (g == DEPTH - 1) begin : g_tail
            assign right_data = '0;
         end else begin : g_next
            assign right_data = links[g+1].data;
         end
         bmhq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (CNT_W'(g) < count_ff),
            .left_link  (left_link),
            .right_data (right_data),
            .self_link  (links[g])
         );
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (xfer) begin
         rsp_valid_in = 1'b1;
         if (req_tuser == bmhq_pkg::KIND_INSERT) begin
            rsp_value_in = '0;
            rsp_stat_in  = full ? bmhq_pkg::STAT_DROPPED : bmhq_pkg::STAT_INSERTED;
         end else if (empty) begin
            rsp_value_in = bmhq_pkg::EMPTY_VALUE;
            rsp_stat_in  = bmhq_pkg::STAT_EMPTY;
         end else begin
            rsp_value_in = links[0].data;
            rsp_stat_in  = bmhq_pkg::STAT_REMOVED;
         end
      end
      rsp_occ_in = xfer ? bmhq_pkg::OCC_W'(count_in) : rsp_occ_ff;
      cap_in     = csr_wr_en ? csr_wr_data : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= bmhq_pkg::CAP_W'(bmhq_pkg::CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_stat_ff;

endmodule

// ===== hdl/bmhq_checker.sv =====
// Port-level checks for binary_min_heap_queue_unit, bound to every instance.
// Depends on bmhq_pkg.
module bmhq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bmhq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [bmhq_pkg::STAT_W-1:0]     rsp_tuser
);

   // Every request transfer yields a result in the next cycle.
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no result after request transfer");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Remove on empty reports the empty marker and zero occupancy.
   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bmhq_pkg::STAT_EMPTY |->
      rsp_tdata[31:0] == bmhq_pkg::EMPTY_VALUE && rsp_tdata[36:32] == '0)
      else $error("bad empty-remove result");

   a_insert_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bmhq_pkg::STAT_INSERTED |->
      rsp_tdata[36:32] != '0 && rsp_tdata[31:0] == '0)
      else $error("insert result with zero occupancy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind binary_min_heap_queue_unit bmhq_checker u_bmhq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
